@@ rtl/sktbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sktbl_pkg
// Shared types and constants of the sorted key accumulator table.
// ----------------------------------------------------------------------------
package sktbl_pkg;

    localparam int KEY_W   = 32;
    localparam int CNT_W   = 16;
    localparam int WSUM_W  = 32;
    localparam int WTSUM_W = 24;
    localparam int WGT_W   = 8;
    localparam int VAL_W   = 8;
    localparam int PROD_W  = WGT_W + VAL_W;

    // cells per first-level group of the readout tree
    localparam int GRP_SIZE = 16;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_QHIT     = 3'd3,
        ST_QMISS    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_HIT,
        S_UPD,
        S_RED,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [WSUM_W-1:0]  wsum;
        logic [WTSUM_W-1:0] wtsum;
    } totals_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        totals_t          tot;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              cmp_en;
        logic              upd_en;
        logic              ins;
        logic              acc;
        logic [KEY_W-1:0]  key;
        logic [PROD_W-1:0] prod;
        logic [WGT_W-1:0]  weight;
    } cell_cmd_t;

endpackage

@@ rtl/sktbl_cell.sv @@
// ----------------------------------------------------------------------------
// sktbl_cell
// One table slot: compares its key against the broadcast key, updates its
// totals on a hit and takes the new entry or its left neighbour on insert.
// ----------------------------------------------------------------------------
module sktbl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sktbl_pkg::cell_cmd_t cmd,
    input  sktbl_pkg::entry_t   left_entry,
    input  logic                left_lt,
    output sktbl_pkg::entry_t   entry,
    output logic                lt,
    output logic                eq
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [sktbl_pkg::KEY_W-1:0] key_reg;
    logic [sktbl_pkg::KEY_W-1:0] key_next;
    sktbl_pkg::totals_t          tot_reg;
    sktbl_pkg::totals_t          tot_next;
    logic                        lt_reg;
    logic                        eq_reg;

    logic [sktbl_pkg::CNT_W:0]   cnt_sum;
    logic [sktbl_pkg::WSUM_W:0]  wsum_sum;
    logic [sktbl_pkg::WTSUM_W:0] wtsum_sum;

    always_comb
    begin
        cnt_sum   = {1'b0, tot_reg.cnt} + {{sktbl_pkg::CNT_W{1'b0}}, 1'b1};
        wsum_sum  = {1'b0, tot_reg.wsum}
                  + {{(sktbl_pkg::WSUM_W + 1 - sktbl_pkg::PROD_W){1'b0}}, cmd.prod};
        wtsum_sum = {1'b0, tot_reg.wtsum}
                  + {{(sktbl_pkg::WTSUM_W + 1 - sktbl_pkg::WGT_W){1'b0}}, cmd.weight};
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tot_next   = tot_reg;
        if (cmd.upd_en)
        begin
            if (cmd.ins && !lt_reg)
            begin
                if (left_lt)
                begin
                    valid_next     = 1'b1;
                    key_next       = cmd.key;
                    tot_next.cnt   = {{(sktbl_pkg::CNT_W-1){1'b0}}, 1'b1};
                    tot_next.wsum  =
                        {{(sktbl_pkg::WSUM_W - sktbl_pkg::PROD_W){1'b0}}, cmd.prod};
                    tot_next.wtsum =
                        {{(sktbl_pkg::WTSUM_W - sktbl_pkg::WGT_W){1'b0}}, cmd.weight};
                end
                else
                begin
                    // shift up to make room
                    valid_next = left_entry.valid;
                    key_next   = left_entry.key;
                    tot_next   = left_entry.tot;
                end
            end
            else if (cmd.acc && eq_reg)
            begin
                tot_next.cnt   = cnt_sum[sktbl_pkg::CNT_W] ? '1
                               : cnt_sum[sktbl_pkg::CNT_W-1:0];
                tot_next.wsum  = wsum_sum[sktbl_pkg::WSUM_W] ? '1
                               : wsum_sum[sktbl_pkg::WSUM_W-1:0];
                tot_next.wtsum = wtsum_sum[sktbl_pkg::WTSUM_W] ? '1
                               : wtsum_sum[sktbl_pkg::WTSUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.cmp_en)
            begin
                lt_reg <= valid_reg && (key_reg < cmd.key);
                eq_reg <= valid_reg && (key_reg == cmd.key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tot_reg <= tot_next;
    end

    assign entry = {valid_reg, key_reg, tot_reg};
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

@@ rtl/sorted_key_accumulator_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_key_accumulator_table_core
// Table of keyed accumulators held in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// Each transaction is captured at its acceptance edge and then passes in turn
// through parallel compare in every cell, hit and full detection, the update
// or insert shift through the cell row, a grouped readout of the hit cell and
// the result load. The input is ready again in the cycle after the load, so
// a new transaction is taken only once the last one is through; the output
// register holds the result until it is taken, and a result still waiting
// there holds the next transaction at its load step. The table starts empty
// after reset with no clearing pass; an accumulate miss on a full table is
// dropped and flagged.
module sorted_key_accumulator_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [sktbl_pkg::KEY_W-1:0]       key,
    input  logic [sktbl_pkg::WGT_W-1:0]       weight,
    input  logic [sktbl_pkg::VAL_W-1:0]       sample_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    output logic [sktbl_pkg::CNT_W-1:0]       event_count,
    output logic [sktbl_pkg::WSUM_W-1:0]      weighted_total,
    output logic [sktbl_pkg::WTSUM_W-1:0]     weight_total
);

    localparam int NGRP = (TABLE_DEPTH + sktbl_pkg::GRP_SIZE - 1) / sktbl_pkg::GRP_SIZE;

    sktbl_pkg::state_t state_reg;
    sktbl_pkg::state_t state_next;

    logic                               mode_reg;
    logic [sktbl_pkg::KEY_W-1:0]        key_reg;
    logic [sktbl_pkg::WGT_W-1:0]        weight_reg;
    logic [sktbl_pkg::VAL_W-1:0]        value_reg;
    logic [sktbl_pkg::PROD_W-1:0]       prod_reg;
    logic                               any_hit_reg;
    logic                               full_reg;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    sktbl_pkg::status_t                 status_reg;
    sktbl_pkg::totals_t                 out_tot_reg;

    sktbl_pkg::cell_cmd_t               cmd;
    sktbl_pkg::entry_t                  cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]             lt_vec;
    logic [TABLE_DEPTH-1:0]             eq_vec;
    logic [TABLE_DEPTH-1:0]             valid_vec;

    sktbl_pkg::totals_t                 grp_tot [NGRP];
    sktbl_pkg::totals_t                 grp_reg [NGRP];
    sktbl_pkg::totals_t                 hit_tot;

    logic                               accept;
    logic                               out_load;

    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == sktbl_pkg::S_OUT) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sktbl_pkg::S_IDLE: if (accept) state_next = sktbl_pkg::S_CMP;
            sktbl_pkg::S_CMP:  state_next = sktbl_pkg::S_HIT;
            sktbl_pkg::S_HIT:  state_next = sktbl_pkg::S_UPD;
            sktbl_pkg::S_UPD:  state_next = sktbl_pkg::S_RED;
            sktbl_pkg::S_RED:  state_next = sktbl_pkg::S_OUT;
            sktbl_pkg::S_OUT:  if (out_load) state_next = sktbl_pkg::S_IDLE;
            default:           state_next = sktbl_pkg::S_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.cmp_en = 1'b0;
        cmd.upd_en = 1'b0;
        case (state_reg)
            sktbl_pkg::S_IDLE: in_ready   = 1'b1;
            sktbl_pkg::S_CMP:  cmd.cmp_en = 1'b1;
            sktbl_pkg::S_UPD:  cmd.upd_en = 1'b1;
            default:
            begin
                in_ready   = 1'b0;
                cmd.cmp_en = 1'b0;
                cmd.upd_en = 1'b0;
            end
        endcase
        cmd.acc    = !mode_reg;
        cmd.ins    = !mode_reg && !any_hit_reg && !full_reg;
        cmd.key    = key_reg;
        cmd.prod   = prod_reg;
        cmd.weight = weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sktbl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            key_reg    <= key;
            weight_reg <= weight;
            value_reg  <= sample_value;
        end
        if (state_reg == sktbl_pkg::S_CMP)
            prod_reg <= {{sktbl_pkg::VAL_W{1'b0}}, weight_reg}
                      * {{sktbl_pkg::WGT_W{1'b0}}, value_reg};
        if (state_reg == sktbl_pkg::S_HIT)
        begin
            any_hit_reg <= |eq_vec;
            full_reg    <= valid_vec[TABLE_DEPTH-1];
        end
    end

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            sktbl_pkg::entry_t left_entry;
            logic              left_lt;
            if (gi == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_lt    = 1'b1;
            end
            else
            begin : g_rest
                assign left_entry = cell_entry[gi-1];
                assign left_lt    = lt_vec[gi-1];
            end

            sktbl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_entry (left_entry),
                .left_lt    (left_lt),
                .entry      (cell_entry[gi]),
                .lt         (lt_vec[gi]),
                .eq         (eq_vec[gi])
            );

            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    // readout of the hit cell, first level registered per group
    generate
        for (gi = 0; gi < NGRP; gi++)
        begin : g_grp
            always_comb
            begin
                grp_tot[gi] = '0;
                for (int j = 0; j < sktbl_pkg::GRP_SIZE; j++)
                begin
                    if (gi * sktbl_pkg::GRP_SIZE + j < TABLE_DEPTH)
                    begin
                        if (eq_vec[gi * sktbl_pkg::GRP_SIZE + j])
                            grp_tot[gi] = grp_tot[gi]
                                        | cell_entry[gi * sktbl_pkg::GRP_SIZE + j].tot;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (state_reg == sktbl_pkg::S_RED)
                    grp_reg[gi] <= grp_tot[gi];
            end
        end
    endgenerate

    always_comb
    begin
        hit_tot = '0;
        for (int g = 0; g < NGRP; g++)
            hit_tot = hit_tot | grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (mode_reg)
            begin
                status_reg  <= any_hit_reg ? sktbl_pkg::ST_QHIT : sktbl_pkg::ST_QMISS;
                out_tot_reg <= any_hit_reg ? hit_tot : '0;
            end
            else if (any_hit_reg)
            begin
                status_reg  <= sktbl_pkg::ST_UPDATED;
                out_tot_reg <= hit_tot;
            end
            else if (full_reg)
            begin
                status_reg  <= sktbl_pkg::ST_FULL;
                out_tot_reg <= '0;
            end
            else
            begin
                status_reg        <= sktbl_pkg::ST_INSERTED;
                out_tot_reg.cnt   <= {{(sktbl_pkg::CNT_W-1){1'b0}}, 1'b1};
                out_tot_reg.wsum  <=
                    {{(sktbl_pkg::WSUM_W - sktbl_pkg::PROD_W){1'b0}}, prod_reg};
                out_tot_reg.wtsum <=
                    {{(sktbl_pkg::WTSUM_W - sktbl_pkg::WGT_W){1'b0}}, weight_reg};
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign event_count    = out_tot_reg.cnt;
    assign weighted_total = out_tot_reg.wsum;
    assign weight_total   = out_tot_reg.wtsum;

    // valid cells always form a prefix of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1}) & valid_vec) == '0)
        else $error("occupied cells are not contiguous from the first cell");

    // a key is held by at most one cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sktbl_pkg::S_HIT) |-> $onehot0(eq_vec))
        else $error("key matched in more than one cell");

    // no insert, no change of occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sktbl_pkg::S_UPD && !cmd.ins) |=> $stable(valid_vec))
        else $error("occupancy changed without an insert");

    // a freshly inserted entry reports a single event
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == sktbl_pkg::ST_INSERTED)
        |-> (out_tot_reg.cnt == {{(sktbl_pkg::CNT_W-1){1'b0}}, 1'b1}))
        else $error("inserted entry with event count other than one");

endmodule
